/* rtl/sliding_window_ack_engine_macros.svh */
// Assertion macros for the window engine checker
`ifndef SLIDING_WINDOW_ACK_ENGINE_MACROS_SVH
`define SLIDING_WINDOW_ACK_ENGINE_MACROS_SVH

// Same-cycle implication, quiet while reset is low
`define SWAE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet while reset is low
`define SWAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/swae_pkg.sv */
package swae_pkg;

  localparam int WINDOW_MAX    = 1024;
  localparam int DUP_THRESHOLD = 3;
  localparam int SLOT_W        = $clog2(WINDOW_MAX);
  localparam int WIN_W         = $clog2(WINDOW_MAX + 1);
  localparam int CNT_W         = 5;

  localparam logic [1:0] OP_HANDSHAKE = 2'd0;
  localparam logic [1:0] OP_SENT      = 2'd1;
  localparam logic [1:0] OP_ACK       = 2'd2;
  localparam logic [1:0] OP_TIMEOUT   = 2'd3;

  localparam logic [2:0] ACT_IGNORED   = 3'd0;
  localparam logic [2:0] ACT_ADVANCED  = 3'd1;
  localparam logic [2:0] ACT_FAST_RETX = 3'd2;
  localparam logic [2:0] ACT_TMO_RETX  = 3'd3;
  localparam logic [2:0] ACT_SENT      = 3'd4;
  localparam logic [2:0] ACT_HANDSHAKE = 3'd5;

  localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [1:0] CFG_FULL_PAYLOAD = 2'd1;
  localparam logic [1:0] CFG_RTO_FLOOR    = 2'd2;

  localparam logic [11:0] CREDIT_MAX = 12'd2048;

  typedef struct packed {
    logic             start;
    logic [31:0]      dividend;
    logic [WIN_W-1:0] divisor;
  } mod_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] slot;
  } mod_stat_t;

endpackage

/* rtl/swae_mod.sv */
module swae_mod (
  input  logic                clk,
  input  logic                rst_n,
  input  swae_pkg::mod_ctrl_t ctrl,
  output swae_pkg::mod_stat_t stat
);
  import swae_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      dvd_r;
  logic [WIN_W-1:0] div_r;
  logic [WIN_W-1:0] rem_r;
  logic [WIN_W:0]   trial;
  logic [WIN_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[31]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = WIN_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= ctrl.dividend;
        div_r  <= ctrl.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[30:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done_r;
  assign stat.slot = rem_r[SLOT_W-1:0];

endmodule

/* rtl/sliding_window_ack_engine.sv */
// Sender-side sliding-window ACK engine with a Jacobson retransmission timer.
// Input channel (in_*): one event per transaction, chosen by in_op: handshake
// reply, packet sent, ACK received or timeout. Result channel (out_*): exactly
// one result transaction per input transaction, in order.
// Configuration (cfg_*): write window size, full payload size and RTO floor
// by index while the engine is idle; a write takes effect at once.
// States after acceptance: handshake DEC, RTO, OUT; stale or plain duplicate
// ACK DEC, OUT; send, timeout and fast retransmit DEC, MOD, OUT; advancing
// ACK DEC, MOD, RD, MUL, RTO if it takes an RTT sample, CRD, OUT. MOD waits
// for the slot index, sequence modulo the window, which a shared restoring
// remainder unit forms one bit per cycle.
// One transaction is worked on at a time: in_stall is high from acceptance
// until the result has been loaded into the output register, so the next
// transaction is not accepted before the previous result is offered.
// A stalled result holds in its output register until taken.
// Reset (synchronous, active low) clears sequence, RTT, counter and window
// state and the configuration returns to window 16, payload 1464, floor 10 ms.
// The slot time and size memories are not cleared.
module sliding_window_ack_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_now_us,
  input  logic [31:0] in_ack_seq,
  input  logic [15:0] in_recv_window,
  input  logic [10:0] in_payload_bytes,
  input  logic [23:0] in_sample_rtt_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [31:0] out_retx_seq,
  output logic [11:0] out_credit_release,
  output logic [25:0] out_rto_us,
  output logic [10:0] out_effective_window,
  output logic [31:0] out_send_base,
  output logic [47:0] out_bytes_acked,
  output logic [31:0] out_fast_retx_count,
  output logic [31:0] out_timeout_count
);
  import swae_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DEC, ST_MOD, ST_RD, ST_MUL, ST_RTO, ST_CRD, ST_OUT
  } state_t;

  state_t state_r;

  logic [10:0] window_size_r;
  logic [10:0] full_payload_r;
  logic [19:0] rto_floor_r;

  logic [31:0] base_r, next_r;
  logic [7:0]  dup_count_r, asa_r;
  logic [31:0] dup_target_r;
  logic        dup_valid_r;
  logic [26:0] est_r, dev_r;
  logic [25:0] rto_r;
  logic [31:0] rel_r;
  logic [WIN_W-1:0] wnow_r;
  logic [47:0] bytes_r;
  logic [31:0] fast_r, tmo_r;

  logic [1:0]  op_r;
  logic [31:0] now_r, ack_r;
  logic [15:0] rwin_r;
  logic [10:0] pay_r;
  logic [23:0] samp_r;
  logic [31:0] d_r;
  logic [2:0]  act_r;
  logic [31:0] retx_r;
  logic [11:0] credit_r;
  logic        smp_r;
  logic        fast_r_flag;
  logic [42:0] prod_r;

  logic [31:0] time_mem [WINDOW_MAX];
  logic [10:0] size_mem [WINDOW_MAX];
  logic [31:0] time_rd_r;
  logic [10:0] size_rd_r;

  mod_ctrl_t mod_ctrl;
  mod_stat_t mod_stat;

  logic [WIN_W-1:0] w_used, wmin;
  logic [31:0] d_c, outst_c, credit_c;
  logic        stale_c;
  logic [7:0]  asa_inc, dup_inc;
  logic [34:0] m_c, diff_c;
  logic [35:0] nd_sum, ne_sum;
  logic [33:0] nd_c;
  logic [32:0] ne_c;
  logic [26:0] floor8, dmax;
  logic [29:0] r_sum;
  logic [26:0] r_c;
  logic [48:0] bytes_sum;

  swae_mod u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (mod_ctrl),
    .stat (mod_stat)
  );

  always_comb begin
    if (window_size_r == '0) begin
      w_used = WIN_W'(1);
    end else if (32'(window_size_r) > 32'(WINDOW_MAX)) begin
      w_used = WIN_W'(WINDOW_MAX);
    end else begin
      w_used = WIN_W'(window_size_r);
    end
    wmin     = (32'(rwin_r) < 32'(w_used)) ? WIN_W'(rwin_r) : w_used;
    d_c      = ack_r - base_r;
    outst_c  = next_r - base_r;
    stale_c  = d_c[31] | (d_c > outst_c);
    asa_inc  = (asa_r == 8'hFF) ? asa_r : asa_r + 8'd1;
    dup_inc  = (dup_count_r == 8'hFF) ? dup_count_r : dup_count_r + 8'd1;
    m_c      = {now_r - time_rd_r, 3'b000};
    diff_c   = (m_c > 35'(est_r)) ? m_c - 35'(est_r) : 35'(est_r) - m_c;
    nd_sum   = 36'(dev_r) + 36'({dev_r, 1'b0}) + 36'(diff_c);
    ne_sum   = 36'({est_r, 3'b000}) - 36'(est_r) + 36'(m_c);
    nd_c     = 34'(nd_sum >> 2);
    ne_c     = 33'(ne_sum >> 3);
    floor8   = 27'({rto_floor_r, 3'b000});
    dmax     = (dev_r > floor8) ? dev_r : floor8;
    r_sum    = 30'(est_r) + 30'({dmax, 2'b00});
    r_c      = 27'(r_sum >> 3);
    bytes_sum = 49'(bytes_r) + 49'(size_rd_r) + 49'(prod_r);
    credit_c = ack_r + 32'(wmin) - rel_r;
  end

  assign in_stall = (state_r != ST_IDLE) | !rst_n;

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE:  window_size_r  <= cfg_wdata[10:0];
        CFG_FULL_PAYLOAD: full_payload_r <= cfg_wdata[10:0];
        CFG_RTO_FLOOR:    rto_floor_r    <= cfg_wdata;
        default: ;
      endcase
    end
    if (!rst_n) begin
      window_size_r  <= 11'd16;
      full_payload_r <= 11'd1464;
      rto_floor_r    <= 20'd10000;
    end
  end

  always_comb begin
    mod_ctrl.start    = 1'b0;
    mod_ctrl.divisor  = w_used;
    mod_ctrl.dividend = base_r;
    if (state_r == ST_DEC) begin
      case (op_r)
        OP_SENT: begin
          mod_ctrl.start    = 1'b1;
          mod_ctrl.dividend = next_r;
        end
        OP_TIMEOUT: mod_ctrl.start = 1'b1;
        OP_ACK: begin
          if (!stale_c && d_c != '0) begin
            mod_ctrl.start    = 1'b1;
            mod_ctrl.dividend = ack_r - 32'd1;
          end else if (!stale_c && dup_count_r != '0 && dup_valid_r &&
                       dup_target_r == ack_r && 32'(dup_inc) == 32'(DUP_THRESHOLD)) begin
            mod_ctrl.start = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MOD && mod_stat.done) begin
      if (op_r == OP_SENT) begin
        time_mem[mod_stat.slot] <= now_r;
        size_mem[mod_stat.slot] <= pay_r;
      end else if (op_r == OP_TIMEOUT || fast_r_flag) begin
        time_mem[mod_stat.slot] <= now_r;
      end
    end
    time_rd_r <= time_mem[mod_stat.slot];
    size_rd_r <= size_mem[mod_stat.slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid    <= 1'b0;
      base_r       <= '0;
      next_r       <= '0;
      dup_count_r  <= '0;
      asa_r        <= '0;
      dup_target_r <= '0;
      dup_valid_r  <= 1'b0;
      est_r        <= '0;
      dev_r        <= '0;
      rto_r        <= '0;
      rel_r        <= '0;
      wnow_r       <= '0;
      bytes_r      <= '0;
      fast_r       <= '0;
      tmo_r        <= '0;
      fast_r_flag  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state_r != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r        <= in_op;
            now_r       <= in_now_us;
            ack_r       <= in_ack_seq;
            rwin_r      <= in_recv_window;
            pay_r       <= in_payload_bytes;
            samp_r      <= in_sample_rtt_us;
            act_r       <= ACT_IGNORED;
            retx_r      <= '0;
            credit_r    <= '0;
            fast_r_flag <= 1'b0;
            state_r     <= ST_DEC;
          end
        end
        ST_DEC: begin
          d_r   <= d_c;
          smp_r <= (dup_count_r == '0) && (asa_r == '0) && (d_c == 32'd1);
          case (op_r)
            OP_HANDSHAKE: begin
              base_r       <= '0;
              next_r       <= '0;
              dup_count_r  <= '0;
              asa_r        <= '0;
              dup_target_r <= '0;
              dup_valid_r  <= 1'b0;
              bytes_r      <= '0;
              fast_r       <= '0;
              tmo_r        <= '0;
              est_r        <= 27'({samp_r, 3'b000});
              dev_r        <= '0;
              wnow_r       <= wmin;
              rel_r        <= 32'(wmin);
              credit_r     <= 12'(wmin);
              act_r        <= ACT_HANDSHAKE;
              state_r      <= ST_RTO;
            end
            OP_SENT: begin
              state_r <= ST_MOD;
            end
            OP_TIMEOUT: begin
              if (tmo_r != '1) tmo_r <= tmo_r + 32'd1;
              retx_r  <= base_r;
              act_r   <= ACT_TMO_RETX;
              state_r <= ST_MOD;
            end
            default: begin
              if (stale_c) begin
                state_r <= ST_OUT;
              end else if (d_c != '0) begin
                state_r <= ST_MOD;
              end else begin
                asa_r   <= asa_inc;
                state_r <= ST_OUT;
                if (dup_count_r == '0) begin
                  dup_target_r <= ack_r;
                  dup_valid_r  <= 1'b1;
                  dup_count_r  <= 8'd1;
                end else if (dup_valid_r && dup_target_r == ack_r) begin
                  dup_count_r <= dup_inc;
                  if (32'(dup_inc) == 32'(DUP_THRESHOLD)) begin
                    if (fast_r != '1) fast_r <= fast_r + 32'd1;
                    retx_r      <= base_r;
                    act_r       <= ACT_FAST_RETX;
                    fast_r_flag <= 1'b1;
                    state_r     <= ST_MOD;
                  end
                end else if (asa_inc > 8'd4) begin
                  dup_valid_r  <= 1'b0;
                  dup_target_r <= '0;
                end
              end
            end
          endcase
        end
        ST_MOD: begin
          if (mod_stat.done) begin
            if (op_r == OP_SENT) begin
              next_r  <= next_r + 32'd1;
              act_r   <= ACT_SENT;
              state_r <= ST_OUT;
            end else if (op_r == OP_TIMEOUT || fast_r_flag) begin
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: begin
          prod_r  <= 43'(d_r - 32'd1) * 43'(full_payload_r);
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          bytes_r <= (bytes_sum > 49'(48'hFFFF_FFFF_FFFF)) ? 48'hFFFF_FFFF_FFFF
                                                           : bytes_sum[47:0];
          if (smp_r) begin
            dev_r   <= (nd_c > 34'h7FF_FFFF) ? 27'h7FF_FFFF : nd_c[26:0];
            est_r   <= (ne_c > 33'h7FF_FFFF) ? 27'h7FF_FFFF : ne_c[26:0];
            state_r <= ST_RTO;
          end else begin
            state_r <= ST_CRD;
          end
        end
        ST_RTO: begin
          rto_r   <= (r_c > 27'h3FF_FFFF) ? 26'h3FF_FFFF : r_c[25:0];
          state_r <= (op_r == OP_HANDSHAKE) ? ST_OUT : ST_CRD;
        end
        ST_CRD: begin
          wnow_r       <= wmin;
          base_r       <= ack_r;
          dup_count_r  <= '0;
          asa_r        <= '0;
          dup_valid_r  <= 1'b0;
          dup_target_r <= '0;
          act_r        <= ACT_ADVANCED;
          if (credit_c[31]) begin
            credit_r <= '0;
          end else if (credit_c > 32'(CREDIT_MAX)) begin
            credit_r <= CREDIT_MAX;
            rel_r    <= rel_r + 32'(CREDIT_MAX);
          end else begin
            credit_r <= credit_c[11:0];
            rel_r    <= rel_r + credit_c;
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_action           <= act_r;
            out_retx_seq         <= retx_r;
            out_credit_release   <= credit_r;
            out_rto_us           <= rto_r;
            out_effective_window <= 11'(wnow_r);
            out_send_base        <= base_r;
            out_bytes_acked      <= bytes_r;
            out_fast_retx_count  <= fast_r;
            out_timeout_count    <= tmo_r;
            state_r              <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/swae_checker.sv */
`include "sliding_window_ack_engine_macros.svh"

module swae_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_action,
  input logic [31:0] out_retx_seq,
  input logic [31:0] out_send_base,
  input logic [11:0] out_credit_release
);
  import swae_pkg::*;

  `SWAE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `SWAE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `SWAE_ASSERT_IMPL(a_fast_retx_base, clk, rst_n, out_valid && out_action == ACT_FAST_RETX, out_retx_seq == out_send_base)
  `SWAE_ASSERT_IMPL(a_credit_cap, clk, rst_n, out_valid, out_credit_release <= CREDIT_MAX)

endmodule

bind sliding_window_ack_engine swae_checker u_swae_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_action        (out_action),
  .out_retx_seq      (out_retx_seq),
  .out_send_base     (out_send_base),
  .out_credit_release(out_credit_release)
);
